FILE: rtl/http_segment_length_check_top_assert.svh
// Assertion macros for the checker file.
`ifndef HTTP_SEGMENT_LENGTH_CHECK_TOP_ASSERT_SVH
`define HTTP_SEGMENT_LENGTH_CHECK_TOP_ASSERT_SVH

// Checked at every clock edge, muted while reset is asserted.
`define HSLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define HSLC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/hslc_pkg.sv
package hslc_pkg;

    localparam int MaxLinesDefault = 32;
    localparam int NameLen         = 15;
    localparam int QueueDepth      = 2;

    localparam logic [31:0] Max32 = 32'hFFFF_FFFF;

    localparam logic [7:0] ChCr  = 8'h0D;
    localparam logic [7:0] ChLf  = 8'h0A;
    localparam logic [7:0] ChSp  = 8'h20;
    localparam logic [7:0] ChTab = 8'h09;
    localparam logic [7:0] ChVt  = 8'h0B;
    localparam logic [7:0] ChFf  = 8'h0C;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;

    localparam logic [1:0] StatusOk     = 2'd0;
    localparam logic [1:0] StatusNoHdr  = 2'd1;
    localparam logic [1:0] StatusNegLen = 2'd2;

    // What the front end knows about a segment once its last byte is in.
    typedef struct packed {
        logic        header_found;
        logic [31:0] header_end_index;
        logic        value_negative;
        logic [31:0] value_acc;
        logic        value_clamped;
    } hslc_summary_t;

    // Lower-case "content-length:" one character at a time.
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        begin
            unique case (idx)
                4'd0:    ch = "c";
                4'd1:    ch = "o";
                4'd2:    ch = "n";
                4'd3:    ch = "t";
                4'd4:    ch = "e";
                4'd5:    ch = "n";
                4'd6:    ch = "t";
                4'd7:    ch = "-";
                4'd8:    ch = "l";
                4'd9:    ch = "e";
                4'd10:   ch = "n";
                4'd11:   ch = "g";
                4'd12:   ch = "t";
                4'd13:   ch = "h";
                4'd14:   ch = ":";
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = c;
            if (c >= "A" && c <= "Z") begin
                r = c | 8'h20;
            end
            return r;
        end
    endfunction

endpackage

FILE: rtl/hslc_front.sv
module hslc_front #(
    parameter int MAX_LINES = hslc_pkg::MaxLinesDefault
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    output logic                    push,
    output hslc_pkg::hslc_summary_t push_data
);
    import hslc_pkg::*;

    localparam int LineCntW = $clog2(MAX_LINES + 1);
    localparam logic [LineCntW-1:0] LineLimit = LineCntW'(MAX_LINES);
    localparam logic [3:0] NameLast = 4'(NameLen - 1);

    typedef enum logic [1:0] {
        PH_NAME,
        PH_SPACE,
        PH_DIGITS,
        PH_IGNORE
    } phase_t;

    logic [31:0]         pos_reg, pos_next;
    logic [1:0]          term_reg, term_next;
    logic [31:0]         hdr_idx_reg, hdr_idx_next;
    logic                found_reg, found_next;
    logic [LineCntW-1:0] line_cnt_reg, line_cnt_next;
    logic                in_line_reg, in_line_next;
    phase_t              phase_reg, phase_next;
    logic [3:0]          name_cnt_reg, name_cnt_next;
    logic                neg_reg, neg_next;
    logic [31:0]         acc_reg, acc_next;
    logic                clamp_reg, clamp_next;
    logic                taken_reg, taken_next;
    logic                stopped_reg, stopped_next;

    logic        is_digit;
    logic [35:0] acc_wide;
    logic [31:0] acc_dig;
    logic        clamp_dig;

    assign is_digit = (data_byte >= "0") && (data_byte <= "9");

    // acc * 10 + digit; a digit's value is its low nibble
    always_comb begin
        acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                 + {32'd0, data_byte[3:0]};
        if (acc_wide[35:32] != 4'd0) begin
            acc_dig   = Max32;
            clamp_dig = 1'b1;
        end else begin
            acc_dig   = acc_wide[31:0];
            clamp_dig = clamp_reg;
        end
    end

    always_comb begin
        phase_t     ph;
        logic [3:0] nc;
        logic       go;

        pos_next      = pos_reg;
        term_next     = term_reg;
        hdr_idx_next  = hdr_idx_reg;
        found_next    = found_reg;
        line_cnt_next = line_cnt_reg;
        in_line_next  = in_line_reg;
        phase_next    = phase_reg;
        name_cnt_next = name_cnt_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        clamp_next    = clamp_reg;
        taken_next    = taken_reg;
        stopped_next  = stopped_reg;
        ph            = phase_reg;
        nc            = name_cnt_reg;
        go            = 1'b1;

        if (!found_reg) begin
            // line parser
            if (!stopped_reg) begin
                if (data_byte == 8'h00) begin
                    stopped_next = 1'b1;
                end else if (data_byte == ChCr || data_byte == ChLf) begin
                    in_line_next = 1'b0;
                end else begin
                    if (!in_line_reg) begin
                        if (taken_reg || line_cnt_reg >= LineLimit) begin
                            stopped_next = 1'b1;
                            go           = 1'b0;
                        end else begin
                            line_cnt_next = line_cnt_reg + 1'b1;
                            in_line_next  = 1'b1;
                            ph            = PH_NAME;
                            nc            = 4'd0;
                        end
                    end
                    if (go) begin
                        phase_next    = ph;
                        name_cnt_next = nc;
                        unique case (ph)
                            PH_NAME: begin
                                if (to_lower(data_byte) == name_char(nc)) begin
                                    name_cnt_next = nc + 4'd1;
                                    if (nc == NameLast) begin
                                        taken_next = 1'b1;
                                        phase_next = PH_SPACE;
                                    end
                                end else begin
                                    phase_next = PH_IGNORE;
                                end
                            end
                            PH_SPACE: begin
                                if (data_byte == ChSp || data_byte == ChTab ||
                                    data_byte == ChVt || data_byte == ChFf) begin
                                    phase_next = PH_SPACE;
                                end else if (data_byte == ChPlus) begin
                                    phase_next = PH_DIGITS;
                                end else if (data_byte == ChMinus) begin
                                    neg_next   = 1'b1;
                                    phase_next = PH_DIGITS;
                                end else if (is_digit) begin
                                    acc_next   = acc_dig;
                                    clamp_next = clamp_dig;
                                    phase_next = PH_DIGITS;
                                end else begin
                                    phase_next = PH_IGNORE;
                                end
                            end
                            PH_DIGITS: begin
                                if (is_digit) begin
                                    acc_next   = acc_dig;
                                    clamp_next = clamp_dig;
                                end else begin
                                    phase_next = PH_IGNORE;
                                end
                            end
                            default: begin
                                phase_next = ph;
                            end
                        endcase
                    end
                end
            end

            // CR LF CR LF search
            if (data_byte == ChCr) begin
                term_next = (term_reg == 2'd2) ? 2'd3 : 2'd1;
            end else if (data_byte == ChLf) begin
                if (term_reg == 2'd1) begin
                    term_next = 2'd2;
                end else if (term_reg == 2'd3) begin
                    found_next   = 1'b1;
                    hdr_idx_next = pos_reg - 32'd3;
                    term_next    = 2'd0;
                end else begin
                    term_next = 2'd0;
                end
            end else begin
                term_next = 2'd0;
            end
        end

        if (pos_reg != Max32) begin
            pos_next = pos_reg + 32'd1;
        end
    end

    assign push                       = accept && last_byte;
    assign push_data.header_found     = found_next;
    assign push_data.header_end_index = hdr_idx_next;
    assign push_data.value_negative   = neg_next;
    assign push_data.value_acc        = acc_next;
    assign push_data.value_clamped    = clamp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            pos_reg      <= 32'd0;
            term_reg     <= 2'd0;
            hdr_idx_reg  <= 32'd0;
            found_reg    <= 1'b0;
            line_cnt_reg <= '0;
            in_line_reg  <= 1'b0;
            phase_reg    <= PH_NAME;
            name_cnt_reg <= 4'd0;
            neg_reg      <= 1'b0;
            acc_reg      <= 32'd0;
            clamp_reg    <= 1'b0;
            taken_reg    <= 1'b0;
            stopped_reg  <= 1'b0;
        end else if (accept) begin
            pos_reg      <= pos_next;
            term_reg     <= term_next;
            hdr_idx_reg  <= hdr_idx_next;
            found_reg    <= found_next;
            line_cnt_reg <= line_cnt_next;
            in_line_reg  <= in_line_next;
            phase_reg    <= phase_next;
            name_cnt_reg <= name_cnt_next;
            neg_reg      <= neg_next;
            acc_reg      <= acc_next;
            clamp_reg    <= clamp_next;
            taken_reg    <= taken_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

FILE: rtl/hslc_queue.sv
module hslc_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  hslc_pkg::hslc_summary_t push_data,
    output logic                    full,
    output logic                    not_empty,
    input  logic                    pop,
    output hslc_pkg::hslc_summary_t pop_data
);
    import hslc_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

    hslc_summary_t       slot_reg [QueueDepth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;

    assign full      = (count_reg == CntFull);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/hslc_back.sv
module hslc_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_not_empty,
    input  hslc_pkg::hslc_summary_t q_data,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic [31:0]             m_total_length,
    output logic                    m_saturated
);
    import hslc_pkg::*;

    logic        m_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [31:0] total_reg, total_next;
    logic        sat_reg, sat_next;
    logic [33:0] sum;

    assign q_pop = q_not_empty && (!m_valid_reg || m_ready);
    assign sum   = {2'b00, q_data.header_end_index} + 34'd4 + {2'b00, q_data.value_acc};

    always_comb begin
        status_next = StatusOk;
        total_next  = 32'd0;
        sat_next    = 1'b0;
        if (!q_data.header_found) begin
            status_next = StatusNoHdr;
        end else if (q_data.value_negative &&
                     (q_data.value_acc != 32'd0 || q_data.value_clamped)) begin
            status_next = StatusNegLen;
        end else if (sum[33:32] != 2'b00) begin
            total_next = Max32;
            sat_next   = 1'b1;
        end else begin
            total_next = sum[31:0];
            sat_next   = q_data.value_clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            status_reg <= status_next;
            total_reg  <= total_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_total_length = total_reg;
    assign m_saturated    = sat_reg;

endmodule

FILE: rtl/http_segment_length_check_top.sv
// HTTP segment length check.
// Input channel (s_valid/s_ready): one payload byte per request, s_last_byte
// set on the final byte of a segment. Result channel (m_valid/m_ready): one
// request per segment with status, total length (header end index + 4 +
// content length, 32-bit clamped) and a saturation flag.
// Throughput: one byte per cycle while the result queue has room. The parser
// updates its state in the cycle a byte is taken, so s_ready only depends on
// the result queue. The edge that takes the last byte writes its result into
// the two-entry result queue; the output register loads it, raising m_valid,
// once that register is empty or m_ready is high.
// If the receiver stalls, results pile up in the queue and output register;
// once the queue holds two, s_ready drops until m_ready frees a slot.
// Reset (aresetn low, synchronous) clears the parser, empties the queue and
// drops m_valid. After each last byte the parser starts fresh on the next
// segment.
module http_segment_length_check_top #(
    parameter int MAX_LINES = hslc_pkg::MaxLinesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_total_length,
    output logic        m_saturated
);
    import hslc_pkg::*;

    logic          accept;
    logic          push;
    hslc_summary_t push_data;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    hslc_summary_t q_data;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    hslc_front #(
        .MAX_LINES (MAX_LINES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .push      (push),
        .push_data (push_data)
    );

    hslc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    hslc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_not_empty    (q_not_empty),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_total_length (m_total_length),
        .m_saturated    (m_saturated)
    );

endmodule

FILE: rtl/hslc_checker.sv
`include "http_segment_length_check_top_assert.svh"

module hslc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_total_length,
    input logic        m_saturated
);
    import hslc_pkg::*;

    `HSLC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_total_length) && $stable(m_saturated), "result changed while stalled")
    `HSLC_ASSERT(a_err_zero, m_valid && m_status != StatusOk |-> m_total_length == 32'd0 && !m_saturated, "error result carries length")
    `HSLC_ASSERT(a_sat_max, m_valid && m_saturated |-> m_total_length == 32'hFFFF_FFFF, "saturated total not clamped")
    `HSLC_ASSERT(a_ok_min, m_valid && m_status == StatusOk |-> m_total_length >= 32'd4, "ok total below terminator size")
    `HSLC_ASSERT_ALWAYS(a_rst_idle, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind http_segment_length_check_top hslc_checker u_hslc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_total_length (m_total_length),
    .m_saturated    (m_saturated)
);

FILE: verif/tb_top.sv
module tb_top;
    import hslc_pkg::*;

    localparam int LineLimit  = MaxLinesDefault;
    localparam int StallLimit = 2000;

    typedef enum logic [1:0] {FldName, FldBlank, FldDigits, FldSkip} field_step_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } seg_byte_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] total;
        logic        sat;
    } seg_verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_total_length;
    logic        m_saturated;

    http_segment_length_check_top #(
        .MAX_LINES(LineLimit)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_total_length(m_total_length),
        .m_saturated   (m_saturated)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    seg_byte_t    byte_feed[$];
    logic [7:0]   seg_buf[$];
    seg_verdict_t segment_verdicts[$];
    int unsigned  bytes_issued = 0;
    int unsigned  third = 0;
    int unsigned  src_idle_pct;
    int unsigned  sink_idle_pct;
    int unsigned  mismatches = 0;
    int unsigned  stall_cycles = 0;

    // receiver idles most first, then the sender, then neither
    assign src_idle_pct  = (bytes_issued < third) ? 15 : (bytes_issued < 2 * third) ? 61 : 0;
    assign sink_idle_pct = (bytes_issued < third) ? 61 : (bytes_issued < 2 * third) ? 15 : 0;

    // ---------------- header scan state ----------------
    string       length_key = "content-length:";
    logic [31:0] seg_pos;
    logic [2:0]  crlf_stage;
    logic [31:0] hdr_end;
    logic        hdr_seen;
    int unsigned lines_seen;
    logic        in_line;
    field_step_e fld_step;
    logic [3:0]  key_idx;
    logic        len_neg;
    logic [31:0] len_value;
    logic        len_clamped;
    logic        len_taken;
    logic        scan_done;

    task automatic clear_scan();
        seg_pos     = '0;
        crlf_stage  = '0;
        hdr_end     = '0;
        hdr_seen    = 1'b0;
        lines_seen  = 0;
        in_line     = 1'b0;
        fld_step    = FldName;
        key_idx     = '0;
        len_neg     = 1'b0;
        len_value   = '0;
        len_clamped = 1'b0;
        len_taken   = 1'b0;
        scan_done   = 1'b0;
    endtask

    // Updates the scan state for one accepted byte; on the last byte of a
    // segment pushes the verdict the block must produce.
    task automatic track_segment_byte(input logic [7:0] c, input logic last);
        logic         is_digit;
        logic         add_digit;
        logic [7:0]   lc;
        logic [63:0]  wide;
        seg_verdict_t v;
        is_digit  = (c >= "0" && c <= "9");
        add_digit = 1'b0;
        lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        if (!hdr_seen) begin
            if (!scan_done) begin
                if (c == 8'h00) begin
                    scan_done = 1'b1;
                end else if (c == ChCr || c == ChLf) begin
                    in_line = 1'b0;
                end else if (!in_line && (len_taken || lines_seen >= LineLimit)) begin
                    scan_done = 1'b1;
                end else begin
                    if (!in_line) begin
                        lines_seen++;
                        in_line  = 1'b1;
                        fld_step = FldName;
                        key_idx  = '0;
                    end
                    case (fld_step)
                        FldName: begin
                            if (key_idx < NameLen && lc == length_key[key_idx]) begin
                                key_idx++;
                                if (key_idx == NameLen) begin
                                    len_taken = 1'b1;
                                    fld_step  = FldBlank;
                                end
                            end else begin
                                fld_step = FldSkip;
                            end
                        end
                        FldBlank: begin
                            if (c == ChSp || c == ChTab || c == ChVt || c == ChFf) begin
                                fld_step = FldBlank;
                            end else if (c == ChPlus) begin
                                fld_step = FldDigits;
                            end else if (c == ChMinus) begin
                                len_neg  = 1'b1;
                                fld_step = FldDigits;
                            end else if (is_digit) begin
                                add_digit = 1'b1;
                                fld_step  = FldDigits;
                            end else begin
                                fld_step = FldSkip;
                            end
                        end
                        FldDigits: begin
                            if (is_digit) add_digit = 1'b1;
                            else fld_step = FldSkip;
                        end
                        default: ;
                    endcase
                    if (add_digit) begin
                        wide = {32'd0, len_value} * 64'd10 + {56'd0, c} - 64'd48;
                        if (wide > {32'd0, Max32}) begin
                            wide = {32'd0, Max32};
                            len_clamped = 1'b1;
                        end
                        len_value = wide[31:0];
                    end
                end
            end
            // CR LF CR LF search runs on every byte until the header end is found, zero bytes included
            if (c == ChCr) begin
                crlf_stage = (crlf_stage == 3'd2) ? 3'd3 : 3'd1;
            end else if (c == ChLf) begin
                if (crlf_stage == 3'd1) begin
                    crlf_stage = 3'd2;
                end else if (crlf_stage == 3'd3) begin
                    hdr_seen   = 1'b1;
                    hdr_end    = seg_pos - 32'd3;
                    crlf_stage = 3'd0;
                end else begin
                    crlf_stage = 3'd0;
                end
            end else begin
                crlf_stage = 3'd0;
            end
        end
        if (seg_pos != Max32) seg_pos++;
        if (last) begin
            if (!hdr_seen) begin
                v = '{StatusNoHdr, 32'd0, 1'b0};
            end else if (len_neg && (len_value != 0 || len_clamped)) begin
                v = '{StatusNegLen, 32'd0, 1'b0};
            end else begin
                wide = {32'd0, hdr_end} + 64'd4 + {32'd0, len_value};
                v = '{StatusOk, 32'd0, len_clamped};
                if (wide > {32'd0, Max32}) begin
                    wide  = {32'd0, Max32};
                    v.sat = 1'b1;
                end
                v.total = wide[31:0];
            end
            segment_verdicts.push_back(v);
            clear_scan();
        end
    endtask

    // ---------------- segment builders ----------------
    task automatic put_byte(input logic [7:0] b);
        seg_buf.push_back(b);
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++) seg_buf.push_back(t[i]);
    endtask

    task automatic put_eol();
        put_byte(ChCr);
        put_byte(ChLf);
    endtask

    task automatic put_key_prefix(input int n);
        logic [7:0] ch;
        for (int i = 0; i < n; i++) begin
            ch = length_key[i];
            if (ch >= "a" && ch <= "z" && $urandom_range(1) == 1) ch = ch - 8'd32;
            put_byte(ch);
        end
    endtask

    task automatic put_junk_text(input int n);
        logic [7:0] b;
        repeat (n) begin
            if ($urandom_range(39) == 0) begin
                b = 8'h00;
            end else begin
                do b = $urandom_range(1, 255); while (b == ChCr || b == ChLf);
            end
            put_byte(b);
        end
    endtask

    task automatic put_length_line();
        int unsigned r;
        put_key_prefix(NameLen);
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(3))
                0: put_byte(ChSp);
                1: put_byte(ChTab);
                2: put_byte(ChVt);
                default: put_byte(ChFf);
            endcase
        end
        r = $urandom_range(99);
        if (r < 15) put_byte(ChPlus);
        else if (r < 35) put_byte(ChMinus);
        r = $urandom_range(99);
        if (r < 55) begin
            put_text($sformatf("%0d", $urandom_range(0, 9999)));
        end else if (r < 65) begin
            put_text($sformatf("%0d", $urandom_range(0, 2)));
        end else if (r < 78) begin
            put_text($sformatf("%0d", $urandom()));
        end else if (r < 84) begin
            put_text($sformatf("%0d", 32'hFFFF_FFFF - $urandom_range(0, 200)));
        end else if (r < 92) begin
            repeat ($urandom_range(11, 16)) put_byte(8'h30 + $urandom_range(0, 9));
        end else if (r < 96) begin
            put_text("000");
            put_text($sformatf("%0d", $urandom_range(0, 999)));
        end
        if ($urandom_range(4) == 0) put_junk_text($urandom_range(1, 4));
    endtask

    task automatic put_junk_line();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 3) begin
            put_key_prefix($urandom_range(0, 14));
            put_junk_text($urandom_range(1, 5));
        end else if (r == 3) begin
            put_length_line();
        end else begin
            put_junk_text($urandom_range(1, 8));
        end
    endtask

    task automatic flush_segment();
        for (int i = 0; i < seg_buf.size(); i++)
            byte_feed.push_back('{seg_buf[i], i == seg_buf.size() - 1});
        seg_buf.delete();
    endtask

    task automatic build_random_segment();
        int unsigned r;
        int unsigned n_lines;
        int unsigned len_at;
        r = $urandom_range(99);
        if (r < 12) begin
            // raw noise, heavy on line breaks and zeros
            repeat ($urandom_range(1, 20)) begin
                case ($urandom_range(5))
                    0: put_byte(ChCr);
                    1: put_byte(ChLf);
                    2: put_byte(8'h00);
                    default: put_byte($urandom_range(0, 255));
                endcase
            end
        end else begin
            n_lines = ($urandom_range(14) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 4);
            len_at  = $urandom_range(0, n_lines);
            for (int i = 0; i < n_lines; i++) begin
                if (i == len_at) put_length_line();
                else put_junk_line();
                if ($urandom_range(4) != 0) begin
                    put_eol();
                end else begin
                    repeat ($urandom_range(1, 3)) put_byte($urandom_range(1) ? ChCr : ChLf);
                end
            end
            if (r < 88) begin
                put_eol();
                put_eol();
            end else if (r < 94) begin
                put_byte(ChCr);
                put_byte(ChLf);
                put_byte(ChCr);
            end
            repeat ($urandom_range(0, 5)) put_byte($urandom_range(0, 255));
        end
        if (seg_buf.size() == 0) put_byte($urandom_range(0, 255));
        flush_segment();
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        seg_byte_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                cur = byte_feed.pop_front();
                s_valid      <= 1'b1;
                s_data_byte  <= cur.data;
                s_last_byte  <= cur.last;
                bytes_issued <= bytes_issued + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ---------------- monitor and watchdog ----------------
    always @(posedge aclk) begin
        seg_verdict_t want;
        if (aresetn) begin
            if (s_valid && s_ready) track_segment_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                if (segment_verdicts.size() == 0) begin
                    $error("result with none pending: status %0d total %0d sat %0d",
                           m_status, m_total_length, m_saturated);
                    mismatches++;
                end else begin
                    want = segment_verdicts.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_total_length !== want.total) begin
                        $error("total_length: expected %0d, got %0d",
                               want.total, m_total_length);
                        mismatches++;
                    end
                    if (m_saturated !== want.sat) begin
                        $error("saturated: expected %0d, got %0d", want.sat, m_saturated);
                        mismatches++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= StallLimit) begin
                    $display("tb_top: errors");
                    $finish;
                end
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        clear_scan();

        put_eol();
        put_eol();
        flush_segment();

        put_byte(8'hFF);
        flush_segment();

        put_text("Content-Length: 42");
        put_eol();
        put_eol();
        put_text("xy");
        flush_segment();

        put_text("CONTENT-LENGTH:");
        put_byte(ChTab);
        put_byte(ChVt);
        put_byte(ChFf);
        put_text("-17");
        put_eol();
        put_eol();
        flush_segment();

        put_text("content-length: -0");
        put_eol();
        put_eol();
        flush_segment();

        put_text("content-length:99999999999");
        put_eol();
        put_eol();
        flush_segment();

        put_text("content-length:-99999999999");
        put_eol();
        put_eol();
        flush_segment();

        put_text("Host: a");
        put_eol();
        put_text("content-length:4294967295");
        put_eol();
        put_eol();
        flush_segment();

        put_text("content-length:");
        put_eol();
        put_eol();
        flush_segment();

        // zero byte stops line parsing, terminator still found
        put_text("a");
        put_byte(8'h00);
        put_eol();
        put_text("content-length:5");
        put_eol();
        put_eol();
        flush_segment();

        put_text("content-length:+7x9");
        put_eol();
        put_eol();
        put_byte(8'h80);
        put_byte(8'h00);
        flush_segment();

        while (byte_feed.size() < 1850) build_random_segment();
        third = byte_feed.size() / 3;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        wait (byte_feed.size() == 0 && !s_valid && segment_verdicts.size() == 0);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: http_segment_length_check_top.f
+incdir+rtl
rtl/hslc_pkg.sv
rtl/hslc_front.sv
rtl/hslc_queue.sv
rtl/hslc_back.sv
rtl/http_segment_length_check_top.sv
rtl/hslc_checker.sv
verif/tb_top.sv
